// File: hdl/lla_pkg.sv
// ----------------------------------------------------------------------------
// Life-like automaton package
// Shared types, codes and defaults for the board controller and datapath.
// ----------------------------------------------------------------------------
package lla_pkg;

  // Default board size.
  localparam int BoardWidthDef  = 64;
  localparam int BoardHeightDef = 64;

  // Field widths fixed by the item format.
  localparam int CoordW   = 6;
  localparam int MaskW    = 9;
  localparam int CountW   = 4;
  localparam int ChanW    = 8;
  localparam int GenW     = 32;
  localparam int CfgIdxW  = 2;
  localparam int InDataW  = 16;
  localparam int OutDataW = 64;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgBirthMask   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSurviveMask = 2'd1;

  // Register reset values.
  localparam logic [MaskW-1:0] BirthMaskRst   = 9'd8;
  localparam logic [MaskW-1:0] SurviveMaskRst = 9'd12;

  // Requested action, carried in tuser.
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_STEP  = 2'd2
  } action_e;

  // How a cell came to be.
  typedef enum logic [1:0] {
    KIND_DEAD     = 2'd0,
    KIND_WHITE    = 2'd1,
    KIND_SURVIVED = 2'd2,
    KIND_BORN     = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CountW-1:0] count;
  } cell_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STEP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_en;
    logic sweep_en;
    logic swap;
    logic wr_en;
    logic rd_en;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic sweep_done;
  } status_t;

endpackage

// File: hdl/lla_ctrl.sv
// ----------------------------------------------------------------------------
// Life-like automaton controller
// Handshakes, read pipeline tracking and the clear/idle/step state machine.
// ----------------------------------------------------------------------------
module lla_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  logic [1:0]      s_user_i,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  output lla_pkg::cmd_t   cmd_o,
  input  lla_pkg::status_t status_i
);

  lla_pkg::state_e state_q, state_d;
  logic pend_q, pend_d;
  logic out_valid_q, out_valid_d;
  logic out_free, accept, act_wr, act_rd, act_step;

  // The output register is free when empty or being drained.
  assign out_free  = !out_valid_q || m_ready_i;
  assign s_ready_o = (state_q == lla_pkg::ST_IDLE) && (!pend_q || out_free);
  assign accept    = s_valid_i && s_ready_o;
  assign m_valid_o = out_valid_q;

  // Action decode.
  always_comb begin
    act_wr   = 1'b0;
    act_rd   = 1'b0;
    act_step = 1'b0;
    unique case (lla_pkg::action_e'(s_user_i))
      lla_pkg::ACT_WRITE: act_wr = accept;
      lla_pkg::ACT_READ:  act_rd = accept;
      lla_pkg::ACT_STEP:  act_step = accept;
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lla_pkg::ST_CLEAR: if (status_i.clear_done) state_d = lla_pkg::ST_IDLE;
      lla_pkg::ST_IDLE:  if (act_step) state_d = lla_pkg::ST_STEP;
      lla_pkg::ST_STEP: begin
        if (!pend_q && status_i.sweep_done) state_d = lla_pkg::ST_IDLE;
      end
      default: state_d = lla_pkg::ST_IDLE;
    endcase
  end

  // Commands. The sweep waits until a pending read has left the memory port.
  always_comb begin
    cmd_o          = '0;
    cmd_o.clr_en   = (state_q == lla_pkg::ST_CLEAR);
    cmd_o.sweep_en = (state_q == lla_pkg::ST_STEP) && !pend_q;
    cmd_o.swap     = cmd_o.sweep_en && status_i.sweep_done;
    cmd_o.wr_en    = act_wr;
    cmd_o.rd_en    = act_rd;
    cmd_o.load_out = pend_q && out_free;
  end

  // Read pipeline occupancy.
  always_comb begin
    pend_d      = act_rd ? 1'b1 : (out_free ? 1'b0 : pend_q);
    out_valid_d = (pend_q && out_free) ? 1'b1 : (m_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lla_pkg::ST_CLEAR;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A read whose result cannot move on stays pending with its result held.
  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && out_valid_q && !m_ready_i |=> pend_q && out_valid_q)
    else $error("pending read lost under stall");

  // An accepted read is tracked in the next cycle.
  a_rd_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |=> pend_q)
    else $error("accepted read not tracked");

  // Finishing a sweep returns the block to idle.
  a_swap_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.swap |=> state_q == lla_pkg::ST_IDLE)
    else $error("sweep end did not return to idle");

  // The sweep never shares the memory port with a pending read.
  a_sweep_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sweep_en |-> !pend_q && !cmd_o.rd_en)
    else $error("sweep overlaps a read");

endmodule

// File: hdl/lla_datapath.sv
// ----------------------------------------------------------------------------
// Life-like automaton datapath
// Two cell banks, the neighbour window shift line, rule logic and registers.
// ----------------------------------------------------------------------------
module lla_datapath #(
  parameter int BOARD_WIDTH  = lla_pkg::BoardWidthDef,
  parameter int BOARD_HEIGHT = lla_pkg::BoardHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lla_pkg::cmd_t                 cmd_i,
  output lla_pkg::status_t              status_o,
  input  logic [lla_pkg::CoordW-1:0]    cell_x_i,
  input  logic [lla_pkg::CoordW-1:0]    cell_y_i,
  input  logic                          alive_in_i,
  input  logic                          cfg_we_i,
  input  logic [lla_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lla_pkg::MaskW-1:0]     cfg_data_i,
  output logic [lla_pkg::OutDataW-1:0]  out_data_o
);

  localparam int NumCells = BOARD_WIDTH * BOARD_HEIGHT;
  localparam int AddrW    = $clog2(NumCells);
  localparam int CntW     = $clog2(NumCells + BOARD_WIDTH + 3);
  localparam int XW       = $clog2(BOARD_WIDTH);
  localparam int YW       = $clog2(BOARD_HEIGHT);
  localparam int WinLen   = 2 * BOARD_WIDTH + 3;
  localparam int Lag      = BOARD_WIDTH + 3;

  lla_pkg::cell_t bank0_q [NumCells];
  lla_pkg::cell_t bank1_q [NumCells];
  lla_pkg::cell_t rd0_q, rd1_q, rd_cell;

  logic [CntW-1:0]  cnt_q;
  logic [XW-1:0]    cx_q;
  logic [YW-1:0]    cy_q;
  logic             cur_q;
  logic [lla_pkg::GenW-1:0]  gen_q;
  logic [lla_pkg::MaskW-1:0] birth_q, survive_q;
  logic [WinLen-1:0] win_q;
  logic             pend_on_q;
  logic [lla_pkg::OutDataW-1:0] out_q;

  logic [AddrW-1:0] usr_addr, rd_addr, usr_waddr, swp_addr;
  logic             on_board, usr_we, swp_we, rd_en, new_bit;
  lla_pkg::cell_t   usr_wdata, swp_wdata;
  logic top, bot, lft, rgt;
  logic [lla_pkg::CountW-1:0] nbr;
  lla_pkg::kind_e   nkind;
  logic [11:0]      shade_w;
  logic [lla_pkg::ChanW-1:0] shade, c1, c2, c3;
  logic             alive;

  // Address of the requested cell.
  assign on_board = (int'(cell_x_i) < BOARD_WIDTH) && (int'(cell_y_i) < BOARD_HEIGHT);
  assign usr_addr = AddrW'(int'(cell_y_i) * BOARD_WIDTH + int'(cell_x_i));

  // Current bank write side: clearing pass or cell writes.
  assign usr_we    = cmd_i.clr_en || (cmd_i.wr_en && on_board);
  assign usr_waddr = cmd_i.clr_en ? cnt_q[AddrW-1:0] : usr_addr;
  always_comb begin
    usr_wdata       = '0;
    usr_wdata.kind  = (!cmd_i.clr_en && alive_in_i) ? lla_pkg::KIND_WHITE
                                                    : lla_pkg::KIND_DEAD;
  end

  // Shared read port of the current bank.
  assign rd_en   = (cmd_i.sweep_en && (cnt_q < CntW'(NumCells))) || cmd_i.rd_en;
  assign rd_addr = cmd_i.sweep_en ? cnt_q[AddrW-1:0] : usr_addr;

  // Bank 0.
  always_ff @(posedge clk_i) begin
    if (!cur_q ? usr_we : swp_we) begin
      bank0_q[!cur_q ? usr_waddr : swp_addr] <= !cur_q ? usr_wdata : swp_wdata;
    end
    if (rd_en) begin
      rd0_q <= bank0_q[rd_addr];
    end
  end

  // Bank 1.
  always_ff @(posedge clk_i) begin
    if (cur_q ? usr_we : swp_we) begin
      bank1_q[cur_q ? usr_waddr : swp_addr] <= cur_q ? usr_wdata : swp_wdata;
    end
    if (rd_en) begin
      rd1_q <= bank1_q[rd_addr];
    end
  end

  assign rd_cell = cur_q ? rd1_q : rd0_q;

  // Sweep counter, also used by the clearing pass.
  assign status_o.clear_done = (cnt_q == CntW'(NumCells - 1));
  assign status_o.sweep_done = (cnt_q == CntW'(NumCells + BOARD_WIDTH + 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      cnt_q <= status_o.clear_done ? '0 : cnt_q + 1'b1;
    end else if (cmd_i.sweep_en) begin
      cnt_q <= status_o.sweep_done ? '0 : cnt_q + 1'b1;
    end
  end

  // Window of alive bits; newest at bit 0, the center cell at BOARD_WIDTH+1.
  assign new_bit = (cnt_q <= CntW'(NumCells)) && (rd_cell.kind != lla_pkg::KIND_DEAD);
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_en && (cnt_q != '0)) begin
      win_q <= {win_q[WinLen-2:0], new_bit};
    end
  end

  // Center cell position; neighbours past the edge are masked.
  assign top = (cy_q != '0);
  assign bot = (cy_q != YW'(BOARD_HEIGHT - 1));
  assign lft = (cx_q != '0);
  assign rgt = (cx_q != XW'(BOARD_WIDTH - 1));

  assign nbr = lla_pkg::CountW'(top & lft & win_q[2*BOARD_WIDTH+2])
             + lla_pkg::CountW'(top & win_q[2*BOARD_WIDTH+1])
             + lla_pkg::CountW'(top & rgt & win_q[2*BOARD_WIDTH])
             + lla_pkg::CountW'(lft & win_q[BOARD_WIDTH+2])
             + lla_pkg::CountW'(rgt & win_q[BOARD_WIDTH])
             + lla_pkg::CountW'(bot & lft & win_q[2])
             + lla_pkg::CountW'(bot & win_q[1])
             + lla_pkg::CountW'(bot & rgt & win_q[0]);

  // Birth and survival rule.
  always_comb begin
    if (win_q[BOARD_WIDTH+1]) begin
      nkind = survive_q[nbr] ? lla_pkg::KIND_SURVIVED : lla_pkg::KIND_DEAD;
    end else begin
      nkind = birth_q[nbr] ? lla_pkg::KIND_BORN : lla_pkg::KIND_DEAD;
    end
    swp_wdata.kind  = nkind;
    swp_wdata.count = (nkind == lla_pkg::KIND_DEAD) ? '0 : nbr;
  end

  assign swp_we   = cmd_i.sweep_en && (cnt_q >= CntW'(Lag));
  assign swp_addr = AddrW'(cnt_q - CntW'(Lag));

  // Center position, generation and bank select.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cur_q <= 1'b0;
      gen_q <= '0;
    end else if (cmd_i.swap) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cur_q <= !cur_q;
      gen_q <= gen_q + 1'b1;
    end else if (swp_we) begin
      if (!rgt) begin
        cx_q <= '0;
        cy_q <= cy_q + 1'b1;
      end else begin
        cx_q <= cx_q + 1'b1;
      end
    end
  end

  // Rule masks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_q   <= lla_pkg::BirthMaskRst;
      survive_q <= lla_pkg::SurviveMaskRst;
    end else if (cfg_we_i) begin
      if (cfg_index_i == lla_pkg::CfgBirthMask) birth_q <= cfg_data_i;
      if (cfg_index_i == lla_pkg::CfgSurviveMask) survive_q <= cfg_data_i;
    end
  end

  // Pixel colour of the read cell.
  assign shade_w = 12'(rd_cell.count) * 12'd255;
  assign shade   = shade_w[11:4];
  always_comb begin
    c1 = '0;
    c2 = '0;
    c3 = '0;
    if (pend_on_q) begin
      case (rd_cell.kind)
        lla_pkg::KIND_WHITE: begin
          c1 = '1; c2 = '1; c3 = '1;
        end
        lla_pkg::KIND_SURVIVED: begin
          c1 = '1; c2 = shade; c3 = '1;
        end
        lla_pkg::KIND_BORN: begin
          c1 = shade; c2 = '1; c3 = '1;
        end
        default: ;
      endcase
    end
    alive = |{c1, c2, c3};
  end

  // Read result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      pend_on_q <= on_board;
    end
    if (cmd_i.load_out) begin
      out_q <= {7'd0, gen_q, alive, c3, c2, c1};
    end
  end

  assign out_data_o = out_q;

endmodule

// File: hdl/life_like_automaton_step.sv
// ----------------------------------------------------------------------------
// Life-like automaton step
// Board of cells with write, read and one-generation advance under B/S masks.
// ----------------------------------------------------------------------------
//  Channel  Dir  Fields (low bit first)
//  s_axis   in   tuser: action; tdata: cell_x, cell_y, alive_in
//  m_axis   out  tdata: chan_first, chan_second, chan_third, alive_out,
//                generation
//  cfg      in   cfg_index_i, cfg_data_i (birth mask, survive mask)
//
//  Writes and reads are accepted back to back unless the output stalls; a
//  read result passes the bank read register, then the output register.
//  A step sweeps the board through one memory read port, input held off.
//  After reset a clearing pass over every cell runs before the first
//  input transaction; configuration writes are always taken.
//  A stalled output holds at most one more read in flight.
// ----------------------------------------------------------------------------
module life_like_automaton_step #(
  parameter int BOARD_WIDTH  = lla_pkg::BoardWidthDef,
  parameter int BOARD_HEIGHT = lla_pkg::BoardHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [5:0] cell_x, [11:6] cell_y, [12] alive_in
  input  logic [lla_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] action
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] chan_first, [15:8] chan_second, [23:16] chan_third,
  // [24] alive_out, [56:25] generation
  output logic [lla_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lla_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lla_pkg::MaskW-1:0]     cfg_data_i
);

  lla_pkg::cmd_t    cmd;
  lla_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  // Controller.
  lla_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_user_i  (s_axis_tuser),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd),
    .status_i  (status)
  );

  // Datapath.
  lla_datapath #(
    .BOARD_WIDTH  (BOARD_WIDTH),
    .BOARD_HEIGHT (BOARD_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cell_x_i    (s_axis_tdata[5:0]),
    .cell_y_i    (s_axis_tdata[11:6]),
    .alive_in_i  (s_axis_tdata[12]),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: test/life_like_automaton_step_tb.sv
// ----------------------------------------------------------------------------
// Life-like automaton step testbench
// Drives write, read and step transactions into the board, keeps its own copy
// of the board and rule masks, and checks every read pixel field by field.
// Rule masks are changed between phases, with sender and receiver idling
// patterns varied from phase to phase.
// ----------------------------------------------------------------------------
module life_like_automaton_step_tb;

  localparam int W = lla_pkg::BoardWidthDef;
  localparam int H = lla_pkg::BoardHeightDef;
  localparam int Cells = W * H;
  // Sweep length plus margin, used before a mask change and at the end.
  localparam int SettleCycles = Cells + W + 200;

  // Codes outside the defined sets, used to check that they are ignored.
  localparam lla_pkg::action_e ActUnused = lla_pkg::action_e'(2'd3);
  localparam logic [lla_pkg::CfgIdxW-1:0] CfgUnusedLo = 2'd2;
  localparam logic [lla_pkg::CfgIdxW-1:0] CfgUnusedHi = 2'd3;

  typedef struct packed {
    lla_pkg::action_e           act;
    logic [lla_pkg::CoordW-1:0] x;
    logic [lla_pkg::CoordW-1:0] y;
    logic                       alive;
  } cmd_item_t;

  typedef struct packed {
    logic [lla_pkg::ChanW-1:0] c1;
    logic [lla_pkg::ChanW-1:0] c2;
    logic [lla_pkg::ChanW-1:0] c3;
    logic                      alive;
    logic [lla_pkg::GenW-1:0]  gen;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [lla_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [lla_pkg::OutDataW-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [lla_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [lla_pkg::MaskW-1:0] cfg_data_i = '0;

  life_like_automaton_step DUT (.*);

  always #5 clk_i = ~clk_i;

  // Board copy and rule state.
  lla_pkg::kind_e             board_kind [Cells];
  logic [lla_pkg::CountW-1:0] board_cnt  [Cells];
  logic [lla_pkg::MaskW-1:0]  birth_m = lla_pkg::BirthMaskRst;
  logic [lla_pkg::MaskW-1:0]  survive_m = lla_pkg::SurviveMaskRst;
  logic [lla_pkg::GenW-1:0]   gen_count = '0;

  cmd_item_t pending_cmds[$];
  pixel_t    pixel_queue[$];
  cmd_item_t cur_cmd;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit drain_hold = 0;
  int errors = 0;
  int n_reads = 0;
  int n_steps = 0;

  function automatic bit live_at(int x, int y);
    if (x < 0 || y < 0 || x >= W || y >= H) return 0;
    return board_kind[y * W + x] != lla_pkg::KIND_DEAD;
  endfunction

  // Advance the board copy by one generation.
  task automatic advance_generation();
    lla_pkg::kind_e             nk [Cells];
    logic [lla_pkg::CountW-1:0] nc [Cells];
    int n;
    for (int y = 0; y < H; y++) begin
      for (int x = 0; x < W; x++) begin
        n = 0;
        for (int dy = -1; dy <= 1; dy++)
          for (int dx = -1; dx <= 1; dx++)
            if (!(dx == 0 && dy == 0) && live_at(x + dx, y + dy)) n++;
        nk[y * W + x] = lla_pkg::KIND_DEAD;
        if (live_at(x, y)) begin
          if (survive_m[n]) nk[y * W + x] = lla_pkg::KIND_SURVIVED;
        end else if (birth_m[n]) begin
          nk[y * W + x] = lla_pkg::KIND_BORN;
        end
        nc[y * W + x] = (nk[y * W + x] == lla_pkg::KIND_DEAD) ? '0 : lla_pkg::CountW'(n);
      end
    end
    board_kind = nk;
    board_cnt = nc;
    gen_count++;
  endtask

  // Apply one accepted transaction to the board copy.
  task automatic apply_cmd(cmd_item_t c);
    pixel_t p;
    int idx;
    logic [11:0] shade;
    idx = int'(c.y) * W + int'(c.x);
    case (c.act)
      lla_pkg::ACT_WRITE: begin
        board_kind[idx] = c.alive ? lla_pkg::KIND_WHITE : lla_pkg::KIND_DEAD;
        board_cnt[idx] = '0;
      end
      lla_pkg::ACT_READ: begin
        shade = (12'(board_cnt[idx]) * 12'd255) / 12'd16;
        p = '0;
        case (board_kind[idx])
          lla_pkg::KIND_WHITE: begin
            p.c1 = 8'hff; p.c2 = 8'hff; p.c3 = 8'hff;
          end
          lla_pkg::KIND_SURVIVED: begin
            p.c1 = 8'hff; p.c2 = shade[7:0]; p.c3 = 8'hff;
          end
          lla_pkg::KIND_BORN: begin
            p.c1 = shade[7:0]; p.c2 = 8'hff; p.c3 = 8'hff;
          end
          default: ;
        endcase
        p.alive = (p.c1 | p.c2 | p.c3) != 0;
        p.gen = gen_count;
        pixel_queue.push_back(p);
        n_reads++;
      end
      lla_pkg::ACT_STEP: begin
        advance_generation();
        n_steps++;
      end
      default: ;
    endcase
  endtask

  // Driver: one nonblocking update of tvalid per edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) apply_cmd(cur_cmd);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_cmds.size() > 0 && !(drain_hold && pixel_queue.size() > 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          cur_cmd = pending_cmds.pop_front();
          s_axis_tuser <= cur_cmd.act;
          s_axis_tdata <= {3'b000, cur_cmd.alive, cur_cmd.y, cur_cmd.x};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expected pixel.
  always @(posedge clk_i) begin
    pixel_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_queue.size() == 0) begin
          $error("unexpected result transaction %h", m_axis_tdata);
          errors++;
        end else begin
          e = pixel_queue.pop_front();
          if (m_axis_tdata[7:0] !== e.c1) begin
            $error("chan_first expected %0d actual %0d", e.c1, m_axis_tdata[7:0]);
            errors++;
          end
          if (m_axis_tdata[15:8] !== e.c2) begin
            $error("chan_second expected %0d actual %0d", e.c2, m_axis_tdata[15:8]);
            errors++;
          end
          if (m_axis_tdata[23:16] !== e.c3) begin
            $error("chan_third expected %0d actual %0d", e.c3, m_axis_tdata[23:16]);
            errors++;
          end
          if (m_axis_tdata[24] !== e.alive) begin
            $error("alive_out expected %0d actual %0d", e.alive, m_axis_tdata[24]);
            errors++;
          end
          if (m_axis_tdata[56:25] !== e.gen) begin
            $error("generation expected %0d actual %0d", e.gen, m_axis_tdata[56:25]);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [lla_pkg::CfgIdxW-1:0] idx, logic [lla_pkg::MaskW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == lla_pkg::CfgBirthMask) birth_m = val;
    else if (idx == lla_pkg::CfgSurviveMask) survive_m = val;
  endtask

  task automatic push_cmd(lla_pkg::action_e a, int x, int y, bit al);
    cmd_item_t c;
    c.act = a;
    c.x = x[lla_pkg::CoordW-1:0];
    c.y = y[lla_pkg::CoordW-1:0];
    c.alive = al;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() > 0 || s_axis_tvalid || pixel_queue.size() > 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Random traffic: mostly writes and reads clustered in a window so that
  // neighborhoods get dense, some full-range accesses, rare steps and noise.
  task automatic random_traffic(int count);
    int ox, oy, r, x, y;
    ox = $urandom_range(W - 1);
    oy = $urandom_range(H - 1);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 3) begin
        ox = $urandom_range(W - 1);
        oy = $urandom_range(H - 1);
      end
      if ($urandom_range(99) < 15) begin
        x = $urandom_range(W - 1);
        y = $urandom_range(H - 1);
      end else begin
        x = (ox + $urandom_range(7)) % W;
        y = (oy + $urandom_range(7)) % H;
      end
      r = $urandom_range(99);
      if (r < 50) push_cmd(lla_pkg::ACT_WRITE, x, y, $urandom_range(99) < 55);
      else if (r < 95) push_cmd(lla_pkg::ACT_READ, x, y, 1'($urandom_range(1)));
      else if (r < 97) push_cmd(lla_pkg::ACT_STEP, x, y, 1'($urandom_range(1)));
      else push_cmd(ActUnused, x, y, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    for (int i = 0; i < Cells; i++) begin
      board_kind[i] = lla_pkg::KIND_DEAD;
      board_cnt[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corners, clearing, ignored action, a blinker on the edge.
    push_cmd(lla_pkg::ACT_READ, 0, 0, 0);
    push_cmd(lla_pkg::ACT_WRITE, 0, 0, 1);
    push_cmd(lla_pkg::ACT_WRITE, 63, 63, 1);
    push_cmd(lla_pkg::ACT_READ, 0, 0, 0);
    push_cmd(lla_pkg::ACT_READ, 63, 63, 1);
    push_cmd(lla_pkg::ACT_WRITE, 63, 63, 0);
    push_cmd(lla_pkg::ACT_READ, 63, 63, 0);
    push_cmd(ActUnused, 63, 63, 1);
    push_cmd(lla_pkg::ACT_READ, 63, 63, 0);
    push_cmd(lla_pkg::ACT_WRITE, 0, 1, 1);
    push_cmd(lla_pkg::ACT_WRITE, 0, 2, 1);
    push_cmd(lla_pkg::ACT_WRITE, 30, 31, 1);
    push_cmd(lla_pkg::ACT_WRITE, 31, 31, 1);
    push_cmd(lla_pkg::ACT_WRITE, 32, 31, 1);
    push_cmd(lla_pkg::ACT_STEP, 0, 0, 0);
    push_cmd(lla_pkg::ACT_READ, 1, 1, 0);
    push_cmd(lla_pkg::ACT_READ, 0, 1, 0);
    push_cmd(lla_pkg::ACT_READ, 31, 30, 0);
    push_cmd(lla_pkg::ACT_READ, 31, 31, 0);
    push_cmd(lla_pkg::ACT_STEP, 0, 0, 0);
    push_cmd(lla_pkg::ACT_READ, 30, 31, 0);
    push_cmd(lla_pkg::ACT_READ, 31, 32, 0);
    wait_idle();

    // Phases: rule masks and idling patterns change between them.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: begin
          write_reg(lla_pkg::CfgBirthMask, 9'h000);
          write_reg(lla_pkg::CfgSurviveMask, 9'h000);
        end
        2: begin
          write_reg(lla_pkg::CfgBirthMask, 9'h1ff);
          write_reg(lla_pkg::CfgSurviveMask, 9'h1ff);
        end
        3: begin
          write_reg(lla_pkg::CfgBirthMask, 9'h048);
          write_reg(lla_pkg::CfgSurviveMask, 9'h00c);
        end
        4: begin
          write_reg(CfgUnusedLo, 9'h1ff);
          write_reg(CfgUnusedHi, 9'h000);
        end
        5: begin
          write_reg(lla_pkg::CfgBirthMask, 9'h0aa);
          write_reg(lla_pkg::CfgSurviveMask, 9'h155);
        end
        6: begin
          write_reg(lla_pkg::CfgBirthMask, 9'h155);
          write_reg(lla_pkg::CfgSurviveMask, 9'h0aa);
        end
        7: begin
          write_reg(lla_pkg::CfgBirthMask, lla_pkg::BirthMaskRst);
          write_reg(lla_pkg::CfgSurviveMask, 9'h1ff);
        end
        default: ;
      endcase
      send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 12 : 63) : 0;
      recv_stall_pct = (ph % 4 == 2) ? 63 : ((ph % 4 == 3) ? 12 : 0);
      drain_hold = (ph == 4);
      random_traffic(230);
      wait_idle();
    end
    drain_hold = 0;

    $display("Covered %0d reads and %0d generation steps over eight rule-mask phases,",
             n_reads, n_steps);
    $display("with sender gaps, receiver stalls and a drain-paced phase.");
    if (errors == 0) begin
      $display("life_like_automaton_step_tb: clean");
    end else begin
      $display("life_like_automaton_step_tb: errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #60000000;
    $display("life_like_automaton_step_tb: errors");
    $finish;
  end

endmodule

// File: files.f
hdl/lla_pkg.sv
hdl/lla_ctrl.sv
hdl/lla_datapath.sv
hdl/life_like_automaton_step.sv
test/life_like_automaton_step_tb.sv
